@@ rtl/ithx_pkg.sv @@
// Shared constants and the result type for the IPv4/TCP header extractor.
// No dependencies; imported by ithx_capture, ithx_res_reg and the top level.
package ithx_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 16384;

    localparam int CNT_W = 15;
    localparam int LEN_W = CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(MAX_FRAME_BYTES);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  IHL_MIN        = 4'd5;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;

    // Frame byte positions of the fixed fields
    localparam logic [CNT_W-1:0] POS_ETYPE_HI = CNT_W'(12);
    localparam logic [CNT_W-1:0] POS_ETYPE_LO = CNT_W'(13);
    localparam logic [CNT_W-1:0] POS_VER_IHL  = CNT_W'(14);
    localparam logic [CNT_W-1:0] POS_PROTO    = CNT_W'(23);
    localparam logic [CNT_W-1:0] POS_SRC_LO   = CNT_W'(26);
    localparam logic [CNT_W-1:0] POS_SRC_HI   = CNT_W'(29);
    localparam logic [CNT_W-1:0] POS_DST_LO   = CNT_W'(30);
    localparam logic [CNT_W-1:0] POS_DST_HI   = CNT_W'(33);

    localparam logic [6:0]       ETH_HDR_LEN  = 7'd14;
    localparam logic [CNT_W-1:0] TCP_CAP_LEN  = CNT_W'(14);
    localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(34);
    localparam logic [LEN_W-1:0] TCP_FIX_LEN  = LEN_W'(20);

    // Offsets inside the TCP header
    localparam logic [3:0] TCP_DOFF  = 4'd12;
    localparam logic [3:0] TCP_FLAGS = 4'd13;

    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    localparam logic [13:0] PAY_LEN_MAX = '1;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic        syn_flag;
        logic        ack_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [7:0]  payload_offset;
        logic [13:0] payload_len;
    } hdr_result_t;

endpackage

@@ rtl/ithx_in_reg.sv @@
// Input register stage: holds one incoming frame word until the parser takes it.
// Stands alone; needs nothing from ithx_pkg.
module ithx_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    output logic       frame_ready,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic       advance,
    output logic       word_valid,
    output logic [7:0] word_byte,
    output logic       word_end
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign frame_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (frame_ready)
        begin
            valid_next = frame_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid)
        begin
            byte_reg <= frame_byte;
            end_reg  <= frame_end;
        end
    end

    assign word_valid = valid_reg;
    assign word_byte  = byte_reg;
    assign word_end   = end_reg;

endmodule

@@ rtl/ithx_capture.sv @@
// Header capture and frame check: tracks byte position, grabs header fields,
// and forms the result at the last byte. Depends on ithx_pkg.
module ithx_capture (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            word_byte,
    input  logic                  word_end,
    output ithx_pkg::hdr_result_t res
);
    import ithx_pkg::*;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             too_long_reg, too_long_next;
    logic [15:0]      ether_kind_reg, ether_kind_next;
    logic [3:0]       ip_version_reg, ip_version_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [7:0]       ip_proto_reg, ip_proto_next;
    logic [31:0]      src_addr_reg, src_addr_next;
    logic [31:0]      dst_addr_reg, dst_addr_next;
    logic [15:0]      src_port_reg, src_port_next;
    logic [15:0]      dst_port_reg, dst_port_next;
    logic [31:0]      seq_reg, seq_next;
    logic [3:0]       doff_reg, doff_next;
    logic [7:0]       flags_reg, flags_next;

    logic [CNT_W-1:0] pos;
    logic             pos_too_long;
    logic [6:0]       tcp_start;
    logic [CNT_W-1:0] tcp_start_ext;
    logic [CNT_W-1:0] rel;
    logic             in_tcp;
    logic [LEN_W-1:0] len;
    logic [7:0]       pay_off;
    logic [LEN_W-1:0] pay_len_full;
    logic             frame_ok;

    assign pos           = byte_count_reg;
    assign pos_too_long  = {1'b0, pos} >= MAX_FRAME_LEN;
    assign tcp_start     = ETH_HDR_LEN + {1'b0, ihl_reg, 2'b00};
    assign tcp_start_ext = CNT_W'(tcp_start);
    assign rel           = pos - tcp_start_ext;
    assign in_tcp        = (pos > POS_VER_IHL) && (pos >= tcp_start_ext) && (rel < TCP_CAP_LEN);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        too_long_next   = too_long_reg;
        ether_kind_next = ether_kind_reg;
        ip_version_next = ip_version_reg;
        ihl_next        = ihl_reg;
        ip_proto_next   = ip_proto_reg;
        src_addr_next   = src_addr_reg;
        dst_addr_next   = dst_addr_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;
        seq_next        = seq_reg;
        doff_next       = doff_reg;
        flags_next      = flags_reg;

        if (step)
        begin
            if (word_end)
            begin
                // last byte: result goes out this cycle, start the next frame clean
                byte_count_next = '0;
                too_long_next   = 1'b0;
                ether_kind_next = '0;
                ip_version_next = '0;
                ihl_next        = '0;
                ip_proto_next   = '0;
                src_addr_next   = '0;
                dst_addr_next   = '0;
                src_port_next   = '0;
                dst_port_next   = '0;
                seq_next        = '0;
                doff_next       = '0;
                flags_next      = '0;
            end
            else
            begin
                if (byte_count_reg != CNT_MAX)
                begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
                if (pos_too_long)
                begin
                    too_long_next = 1'b1;
                end
                if (pos == POS_ETYPE_HI)
                begin
                    ether_kind_next[15:8] = word_byte;
                end
                if (pos == POS_ETYPE_LO)
                begin
                    ether_kind_next[7:0] = word_byte;
                end
                if (pos == POS_VER_IHL)
                begin
                    ip_version_next = word_byte[7:4];
                    ihl_next        = word_byte[3:0];
                end
                if (pos == POS_PROTO)
                begin
                    ip_proto_next = word_byte;
                end
                if (pos >= POS_SRC_LO && pos <= POS_SRC_HI)
                begin
                    src_addr_next = {src_addr_reg[23:0], word_byte};
                end
                if (pos >= POS_DST_LO && pos <= POS_DST_HI)
                begin
                    dst_addr_next = {dst_addr_reg[23:0], word_byte};
                end
                if (in_tcp)
                begin
                    case (rel[3:0])
                        4'd0, 4'd1:
                        begin
                            src_port_next = {src_port_reg[7:0], word_byte};
                        end
                        4'd2, 4'd3:
                        begin
                            dst_port_next = {dst_port_reg[7:0], word_byte};
                        end
                        4'd4, 4'd5, 4'd6, 4'd7:
                        begin
                            seq_next = {seq_reg[23:0], word_byte};
                        end
                        TCP_DOFF:
                        begin
                            doff_next = word_byte[7:4];
                        end
                        TCP_FLAGS:
                        begin
                            flags_next = word_byte;
                        end
                        default:
                        begin
                            seq_next = seq_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            too_long_reg   <= 1'b0;
            ether_kind_reg <= '0;
            ip_version_reg <= '0;
            ihl_reg        <= '0;
            ip_proto_reg   <= '0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
            seq_reg        <= '0;
            doff_reg       <= '0;
            flags_reg      <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            too_long_reg   <= too_long_next;
            ether_kind_reg <= ether_kind_next;
            ip_version_reg <= ip_version_next;
            ihl_reg        <= ihl_next;
            ip_proto_reg   <= ip_proto_next;
            src_addr_reg   <= src_addr_next;
            dst_addr_reg   <= dst_addr_next;
            src_port_reg   <= src_port_next;
            dst_port_reg   <= dst_port_next;
            seq_reg        <= seq_next;
            doff_reg       <= doff_next;
            flags_reg      <= flags_next;
        end
    end

    // A frame that passes the length checks is at least 54 bytes long, so the
    // last byte never lands in a captured field: the held registers are final.
    assign len          = {1'b0, pos} + LEN_W'(1);
    assign pay_off      = {1'b0, tcp_start} + {2'b00, doff_reg, 2'b00};
    assign pay_len_full = len - LEN_W'(pay_off);

    assign frame_ok = !too_long_reg && !pos_too_long
                      && (len >= MIN_LEN)
                      && (ether_kind_reg == ETHERTYPE_IPV4)
                      && (ip_version_reg == IP_VERSION_4)
                      && (ihl_reg >= IHL_MIN)
                      && (ip_proto_reg == IP_PROTO_TCP)
                      && (len >= LEN_W'(tcp_start) + TCP_FIX_LEN)
                      && (len >= LEN_W'(pay_off));

    always_comb
    begin
        res = '0;
        if (frame_ok)
        begin
            res.valid_res      = 1'b1;
            res.src_addr       = src_addr_reg;
            res.dst_addr       = dst_addr_reg;
            res.src_port       = src_port_reg;
            res.dst_port       = dst_port_reg;
            res.seq_num        = seq_reg;
            res.syn_flag       = flags_reg[FLAG_SYN];
            res.ack_flag       = flags_reg[FLAG_ACK];
            res.fin_flag       = flags_reg[FLAG_FIN];
            res.rst_flag       = flags_reg[FLAG_RST];
            res.payload_offset = pay_off;
            // saturate a payload length that overflows the field
            if (pay_len_full[LEN_W-1:14] != '0)
            begin
                res.payload_len = PAY_LEN_MAX;
            end
            else
            begin
                res.payload_len = pay_len_full[13:0];
            end
        end
    end

endmodule

@@ rtl/ithx_res_reg.sv @@
// Result register: holds one finished result word until the consumer takes it.
// Depends on ithx_pkg for the result type.
module ithx_res_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  ithx_pkg::hdr_result_t res_in,
    output logic                  can_load,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ithx_pkg::hdr_result_t res_out
);
    import ithx_pkg::*;

    logic        valid_reg, valid_next;
    hdr_result_t res_reg;

    assign can_load = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign result_valid = valid_reg;
    assign res_out      = res_reg;

endmodule

@@ rtl/ipv4_tcp_header_extractor.sv @@
// Top level of the Ethernet/IPv4/TCP header extractor; instantiates
// ithx_in_reg, ithx_capture and ithx_res_reg, and uses ithx_pkg.
//
// Takes an Ethernet frame one byte a word and gives one result word per frame,
// at the byte marked frame_end. Frames stream back to back at one byte per
// clock unless a last byte waits for the result register; a byte is held in
// the input register, and the last byte of a frame is checked against the held
// header fields on its way into the result register, which holds the result.
// The result carries valid_res = 1 only for a well-formed IPv4 TCP frame
// (EtherType 0x0800, version 4, IHL of at least 5, protocol 6, headers complete
// and no more than MAX_FRAME_BYTES bytes); otherwise every field reads zero.
// payload_len counts link padding and saturates at its field maximum. Only the
// last byte of a frame waits for room in the result register; other bytes keep
// flowing while a result stays untaken.
module ipv4_tcp_header_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        valid_res,
    output logic [31:0] src_addr,
    output logic [31:0] dst_addr,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [31:0] seq_num,
    output logic        syn_flag,
    output logic        ack_flag,
    output logic        fin_flag,
    output logic        rst_flag,
    output logic [7:0]  payload_offset,
    output logic [13:0] payload_len
);
    import ithx_pkg::*;

    logic        word_valid;
    logic [7:0]  word_byte;
    logic        word_end;
    logic        advance;
    logic        can_load;
    hdr_result_t res_comb;
    hdr_result_t res_q;

    // hold the last byte of a frame while the result register is full
    assign advance = word_valid && (!word_end || can_load);

    ithx_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .advance     (advance),
        .word_valid  (word_valid),
        .word_byte   (word_byte),
        .word_end    (word_end)
    );

    ithx_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .word_byte (word_byte),
        .word_end  (word_end),
        .res       (res_comb)
    );

    ithx_res_reg u_res_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && word_end),
        .res_in       (res_comb),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .res_out      (res_q)
    );

    assign valid_res      = res_q.valid_res;
    assign src_addr       = res_q.src_addr;
    assign dst_addr       = res_q.dst_addr;
    assign src_port       = res_q.src_port;
    assign dst_port       = res_q.dst_port;
    assign seq_num        = res_q.seq_num;
    assign syn_flag       = res_q.syn_flag;
    assign ack_flag       = res_q.ack_flag;
    assign fin_flag       = res_q.fin_flag;
    assign rst_flag       = res_q.rst_flag;
    assign payload_offset = res_q.payload_offset;
    assign payload_len    = res_q.payload_len;

endmodule
